### hw/rtl/csds_pkg.sv
// Shared constants, types and codes for the centroid squared-distance scorer.
package csds_pkg;

   localparam int CLUSTERS_DEF  = 8;
   localparam int DIMS          = 4;
   localparam int COORD_BITS    = 16;
   localparam int SEL_BITS      = 3;
   localparam int IDX_BITS      = 3;
   localparam int SCORE_BITS    = 35;
   localparam int RECIP_BITS    = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int ADDR_BITS     = 6;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int SUM_BITS      = SQ_BITS + $clog2(DIMS);
   localparam int CENT_BITS     = DIMS * COORD_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP_RESET = 16'hFFFF;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCALE_ENABLE = 1'b0,
      CSR_RECIP_COUNT  = 1'b1
   } csr_idx_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_SCORE = 1'b1
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic                 load_we;
      logic [ADDR_BITS-1:0] load_addr;
      logic                 point_we;
      logic                 issue;
      logic [ADDR_BITS-1:0] issue_addr;
      logic                 issue_last;
   } cmd_type;

   typedef struct packed {
      logic advance;
      logic point_busy;
   } sts_type;

endpackage

### hw/rtl/csds_req_if.sv
// Request channel: load or score requests with valid/ready handshake.
interface csds_req_if
   import csds_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SEL_BITS-1:0] cluster_sel;
   coord_type           coord0;
   coord_type           coord1;
   coord_type           coord2;
   coord_type           coord3;

   modport source (output valid, mode, cluster_sel, coord0, coord1, coord2, coord3,
                   input ready);
   modport sink   (input valid, mode, cluster_sel, coord0, coord1, coord2, coord3,
                   output ready);
endinterface

### hw/rtl/csds_rsp_if.sv
// Result channel: one score per centroid with valid/ready handshake.
interface csds_rsp_if
   import csds_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [IDX_BITS-1:0]          cluster_idx;
   logic signed [SCORE_BITS-1:0] score;
   logic                         last;

   modport source (output valid, cluster_idx, score, last, input ready);
   modport sink   (input valid, cluster_idx, score, last, output ready);
endinterface

### hw/rtl/csds_ctrl.sv
// Controller: request acceptance and per-centroid issue sequencing.
module csds_ctrl
   import csds_pkg::*;
#(
   parameter int CLUSTERS = CLUSTERS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [SEL_BITS-1:0] req_cluster_sel,
   input  sts_type             sts,
   output cmd_type             cmd
);

   localparam int CNT_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLUSTERS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sel_ok;

   assign sel_ok = (7'(req_cluster_sel) < 7'(CLUSTERS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.load_addr  = ADDR_BITS'(req_cluster_sel);
      cmd.issue_addr = ADDR_BITS'(cnt_ff);
      cmd.issue_last = (cnt_ff == CNT_LAST);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !sts.point_busy;
            if (req_valid && req_ready) begin
               unique case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     cmd.load_we = sel_ok;
                  end
                  MODE_SCORE: begin
                     cmd.point_we = 1'b1;
                     cnt_in       = '0;
                     state_in     = ST_RUN;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = sts.advance;
            if (sts.advance) begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
      endcase
   end

endmodule

### hw/rtl/csds_datapath.sv
// Datapath: centroid memory, distance pipeline, scaling, config and result register.
module csds_datapath
   import csds_pkg::*;
#(
   parameter int CLUSTERS = CLUSTERS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  coord_type                req_coord [DIMS],
   input  cmd_type                  cmd,
   output sts_type                  sts,
   csds_rsp_if.source               rsp
);

   localparam int CNT_W  = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int PROD_W = SUM_BITS + RECIP_BITS;

   logic [CENT_BITS-1:0] mem [CLUSTERS];
   logic [CENT_BITS-1:0] wr_data;

   logic                  scale_en_ff;
   logic [RECIP_BITS-1:0] recip_ff;
   coord_type             point_ff [DIMS];

   logic                  advance;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_BITS-1:0]   idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic                  last1_ff, last2_ff, last3_ff, last4_ff;
   logic [CENT_BITS-1:0]  rd_data_ff;
   logic [SQ_BITS-1:0]    sq2_ff [DIMS];
   logic [SUM_BITS-1:0]   sum3_ff;
   logic [SUM_BITS-1:0]   mag4_ff;

   logic signed [COORD_BITS:0]     diff [DIMS];
   logic signed [2*COORD_BITS+1:0] prod [DIMS];
   logic [SUM_BITS-1:0]            sum_c;
   logic [PROD_W-1:0]              scaled;
   logic [SUM_BITS-1:0]            mag_c;

   logic                         rsp_valid_ff;
   logic [IDX_BITS-1:0]          rsp_idx_ff;
   logic signed [SCORE_BITS-1:0] rsp_score_ff;
   logic                         rsp_last_ff;

   assign advance        = !rsp_valid_ff || rsp.ready;
   assign sts.advance    = advance;
   assign sts.point_busy = v1_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_en_ff <= 1'b0;
         recip_ff    <= RECIP_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SCALE_ENABLE: scale_en_ff <= csr_wdata[0];
            CSR_RECIP_COUNT:  recip_ff    <= csr_wdata[RECIP_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      for (int n = 0; n < DIMS; n++) begin
         wr_data[n*COORD_BITS +: COORD_BITS] = req_coord[n];
      end
   end

   // centroid memory
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         mem[cmd.load_addr[CNT_W-1:0]] <= wr_data;
      end
      if (cmd.issue && advance) begin
         rd_data_ff <= mem[cmd.issue_addr[CNT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.point_we) begin
         point_ff <= req_coord;
      end
   end

   always_comb begin
      for (int n = 0; n < DIMS; n++) begin
         diff[n] = {point_ff[n][COORD_BITS-1], point_ff[n]}
                 - {rd_data_ff[n*COORD_BITS+COORD_BITS-1],
                    rd_data_ff[n*COORD_BITS +: COORD_BITS]};
         prod[n] = diff[n] * diff[n];
      end
      sum_c = '0;
      for (int n = 0; n < DIMS; n++) begin
         sum_c = sum_c + SUM_BITS'(sq2_ff[n]);
      end
      scaled = PROD_W'(sum3_ff) * PROD_W'(recip_ff);
      mag_c  = scale_en_ff ? scaled[PROD_W-1:RECIP_BITS] : sum3_ff;
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         idx1_ff      <= IDX_BITS'(cmd.issue_addr);
         last1_ff     <= cmd.issue_last;
         idx2_ff      <= idx1_ff;
         last2_ff     <= last1_ff;
         for (int n = 0; n < DIMS; n++) begin
            sq2_ff[n] <= prod[n][SQ_BITS-1:0];
         end
         idx3_ff      <= idx2_ff;
         last3_ff     <= last2_ff;
         sum3_ff      <= sum_c;
         idx4_ff      <= idx3_ff;
         last4_ff     <= last3_ff;
         mag4_ff      <= mag_c;
         rsp_idx_ff   <= idx4_ff;
         rsp_last_ff  <= last4_ff;
         rsp_score_ff <= SCORE_BITS'(0) - SCORE_BITS'(mag4_ff);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cluster_idx = rsp_idx_ff;
   assign rsp.score       = rsp_score_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

### hw/rtl/centroid_sq_distance_scorer_unit.sv
// Top level of the centroid squared-distance scorer.
//
// Channels: req_ch takes requests (mode 0 loads the four coordinates into
// centroid cluster_sel, mode 1 scores a point); rsp_ch returns, for a score
// request, one result per centroid from index 0 up, last set on the final one.
// Each score is -(squared distance), optionally scaled by recip_count (Q0.16).
// csr_we/csr_index/csr_wdata write scale_enable (0) and recip_count (1).
// A load request produces no result. A score request gives its first result
// through the memory read, square, sum, scale and result registers. While
// rsp_ch does not stall, results come one per cycle and one centroid is read
// per cycle; a new request waits until all are issued and the read stage is empty.
// Reset clears the control state and config registers; centroid contents are
// undefined until loaded. When rsp_ch stalls, the whole distance pipeline
// holds and the result stays on the port.
module centroid_sq_distance_scorer_unit
   import csds_pkg::*;
#(
   parameter int CLUSTERS = CLUSTERS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   csds_req_if.sink                 req_ch,
   csds_rsp_if.source               rsp_ch
);

   cmd_type   cmd;
   sts_type   sts;
   coord_type req_coord [DIMS];
   logic      req_ready;

   assign req_coord[0] = req_ch.coord0;
   assign req_coord[1] = req_ch.coord1;
   assign req_coord[2] = req_ch.coord2;
   assign req_coord[3] = req_ch.coord3;
   assign req_ch.ready = req_ready;

   csds_ctrl #(.CLUSTERS(CLUSTERS)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ready),
      .req_mode        (req_ch.mode),
      .req_cluster_sel (req_ch.cluster_sel),
      .sts             (sts),
      .cmd             (cmd)
   );

   csds_datapath #(.CLUSTERS(CLUSTERS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_coord (req_coord),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp_ch)
   );

endmodule

### hw/rtl/csds_checker.sv
// Port-level checks for the scorer, bound to the top level.
module csds_checker
   import csds_pkg::*;
#(
   parameter int CLUSTERS = CLUSTERS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [IDX_BITS-1:0]          rsp_cluster_idx,
   input logic signed [SCORE_BITS-1:0] rsp_score,
   input logic                         rsp_last
);

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_cluster_idx == IDX_BITS'(CLUSTERS - 1))
      else $error("last flag on wrong centroid");

   a_score_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score == '0 || rsp_score[SCORE_BITS-1])
      else $error("positive score");

   a_idx_zero_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_cluster_idx == '0)
      else $error("run does not start at centroid zero");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score)
                                  && $stable(rsp_cluster_idx) && $stable(rsp_last))
      else $error("result changed while stalled");

endmodule

bind centroid_sq_distance_scorer_unit csds_checker #(.CLUSTERS(CLUSTERS)) u_csds_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_cluster_idx (rsp_ch.cluster_idx),
   .rsp_score       (rsp_ch.score),
   .rsp_last        (rsp_ch.last)
);

### tb/tb_centroid_sq_distance_scorer_unit.sv
// Testbench for the centroid squared-distance scorer: loads centroids, scores points, checks.
module tb_centroid_sq_distance_scorer_unit
   import csds_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              CLK_PERIOD   = 10;
   localparam int              SETTLE_CYCLES = 12;
   localparam int              PHASE_ITEMS  = 44;
   localparam longint unsigned DIST_LIMIT   = 64'd1 << 34;

   typedef struct {
      mode_type            mode;
      logic [SEL_BITS-1:0] sel;
      coord_type           coord [DIMS];
   } request_type;

   typedef struct {
      logic [IDX_BITS-1:0]          idx;
      logic signed [SCORE_BITS-1:0] score;
      logic                         last;
   } score_type;

   class score_board_type;
      coord_type             centroid [CLUSTERS_DEF][DIMS];
      logic                  scale_on;
      logic [RECIP_BITS-1:0] recip;
      score_type             expected_scores [$];
      int                    errors;

      function new();
         scale_on = 1'b0;
         recip    = RECIP_RESET;
         errors   = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_SCALE_ENABLE: scale_on = value[0];
            CSR_RECIP_COUNT:  recip    = value[RECIP_BITS-1:0];
            default: ;
         endcase
      endfunction

      // loads update the centroid copy; scores queue one entry per centroid
      function void note_request(request_type r);
         longint unsigned mag;
         longint signed   diff;
         score_type       e;
         if (r.mode == MODE_LOAD) begin
            if (r.sel < CLUSTERS_DEF)
               for (int n = 0; n < DIMS; n++) centroid[r.sel][n] = r.coord[n];
            return;
         end
         for (int k = 0; k < CLUSTERS_DEF; k++) begin
            mag = 0;
            for (int n = 0; n < DIMS; n++) begin
               diff = longint'(r.coord[n]) - longint'(centroid[k][n]);
               mag += longint'(diff * diff);
            end
            if (mag > DIST_LIMIT) mag = DIST_LIMIT;
            if (scale_on) mag = (mag * recip) >> 16;
            e.idx   = k[IDX_BITS-1:0];
            e.score = SCORE_BITS'(64'd0 - mag);
            e.last  = (k == CLUSTERS_DEF - 1);
            expected_scores.push_back(e);
         end
      endfunction

      function void check_result(logic [IDX_BITS-1:0] idx, logic signed [SCORE_BITS-1:0] score,
                                 logic last);
         score_type e;
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result cluster_idx %0d score %0d last %0b",
                     $time, idx, score, last);
            errors++;
            return;
         end
         e = expected_scores.pop_front();
         if (idx !== e.idx) begin
            $display("%0t: cluster_idx expected %0d actual %0d", $time, e.idx, idx);
            errors++;
         end
         if (score !== e.score) begin
            $display("%0t: score (cluster %0d) expected %0d actual %0d",
                     $time, e.idx, e.score, score);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last (cluster %0d) expected %0b actual %0b",
                     $time, e.idx, e.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_scores.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     send_burst = 1'b0;

   score_board_type board = new();

   csds_req_if req_ch ();
   csds_rsp_if rsp_ch ();

   centroid_sq_distance_scorer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic request_type make_item(mode_type mode, logic [SEL_BITS-1:0] sel,
                                             coord_type c0, coord_type c1,
                                             coord_type c2, coord_type c3);
      request_type r;
      r.mode     = mode;
      r.sel      = sel;
      r.coord[0] = c0;
      r.coord[1] = c1;
      r.coord[2] = c2;
      r.coord[3] = c3;
      return r;
   endfunction

   // extremes and small values weighted in alongside full-range values
   function automatic coord_type random_coord();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3:    return coord_type'($urandom_range(0, 511) - 256);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic request_type random_item();
      mode_type mode;
      mode = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_SCORE;
      return make_item(mode, SEL_BITS'($urandom_range(0, CLUSTERS_DEF - 1)), random_coord(),
                       random_coord(), random_coord(), random_coord());
   endfunction

   task automatic send_request(input request_type r);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= r.mode;
      req_ch.cluster_sel <= r.sel;
      req_ch.coord0      <= r.coord[0];
      req_ch.coord1      <= r.coord[1];
      req_ch.coord2      <= r.coord[2];
      req_ch.coord3      <= r.coord[3];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain_requests();
      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   initial begin
      int                    stall;
      logic                  burst;
      burst = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 5);
         if ($urandom_range(0, 15) == 0) burst = !burst;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         board.check_result(rsp_ch.cluster_idx, rsp_ch.score, rsp_ch.last);
      end
   end

   initial begin
      logic                  scale;
      logic [RECIP_BITS-1:0] recip;
      request_type           match_pt;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SCALE_ENABLE;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_LOAD;
      req_ch.cluster_sel <= '0;
      req_ch.coord0      <= '0;
      req_ch.coord1      <= '0;
      req_ch.coord2      <= '0;
      req_ch.coord3      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every centroid loaded before the first score request
      send_request(make_item(MODE_LOAD, 3'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      send_request(make_item(MODE_LOAD, 3'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_request(make_item(MODE_LOAD, 3'd2, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      send_request(make_item(MODE_LOAD, 3'd3, 16'sh7FFF, 16'sh8000, 16'sh0001, -16'sh0001));
      send_request(make_item(MODE_LOAD, 3'd4, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA));
      for (int k = 5; k < CLUSTERS_DEF; k++)
         send_request(make_item(MODE_LOAD, SEL_BITS'(k), random_coord(), random_coord(),
                                random_coord(), random_coord()));
      send_request(make_item(MODE_SCORE, 3'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_request(make_item(MODE_SCORE, 3'd7, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      send_request(make_item(MODE_SCORE, 3'd0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
      match_pt = make_item(MODE_SCORE, 3'd5, 16'sh7FFF, 16'sh8000, 16'sh0001, -16'sh0001);
      send_request(match_pt);
      send_request(make_item(MODE_SCORE, 3'd0, random_coord(), random_coord(),
                             random_coord(), random_coord()));
      // overwrite a centroid, then score against the new value
      send_request(make_item(MODE_LOAD, 3'd2, random_coord(), random_coord(),
                             random_coord(), random_coord()));
      send_request(make_item(MODE_SCORE, 3'd0, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555));
      drain_requests();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       begin scale = 1'b0; recip = 16'hFFFF; end
            1:       begin scale = 1'b1; recip = 16'hFFFF; end
            2:       begin scale = 1'b1; recip = 16'h0001; end
            3:       begin scale = 1'b1; recip = 16'h0000; end
            4:       begin scale = 1'b1; recip = 16'h8000; end
            5:       begin scale = 1'b1; recip = RECIP_BITS'($urandom_range(1, 65535)); end
            default: begin scale = 1'b0; recip = RECIP_BITS'($urandom_range(1, 65535)); end
         endcase
         write_register(CSR_SCALE_ENABLE, CSR_DATA_BITS'(scale));
         write_register(CSR_RECIP_COUNT, recip);
         if (p != 0) send_request(match_pt);
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_item());
         drain_requests();
      end

      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
